// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the cpc_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define CPC_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion, checked at every edge, reset included.
`define CPC_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants and types of the contact penetration correction block.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int POS_W       = 32;
  localparam int NORM_W      = 16;
  localparam int NORM_FRAC   = 14;
  localparam int SHARE_FRAC  = 16;
  localparam int REG_W       = 17;
  localparam int MASS_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [REG_W-1:0] SLOP_RESET  = 17'd655;
  localparam logic [REG_W-1:0] SHARE_RESET = 17'd52429;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARE = 2'd1;

  typedef enum logic [1:0] {
    ST_CORRECTED   = 2'd0,
    ST_BOTH_STATIC = 2'd1,
    ST_IN_SLOP     = 2'd2,
    ST_ZERO_SUM    = 2'd3
  } cpc_status_t;

  // Classified contact, as handed from the front to the back.
  typedef struct packed {
    logic [2:0][POS_W-1:0]  pos_a;
    logic [2:0][POS_W-1:0]  pos_b;
    logic [3*NORM_W-1:0]    normal;
    logic [MASS_W-1:0]      inv_mass_a;
    logic [MASS_W:0]        mass_sum;
    logic [POS_W-1:0]       scaled;
    cpc_status_t            status;
    logic                   static_a;
    logic                   static_b;
  } cpc_item_t;

  typedef struct packed {
    logic      valid;
    cpc_item_t item;
  } cpc_link_t;

endpackage

// ----- design/cpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_front
// Accepts contacts, holds the configuration and classifies each item:
// penetration past slop, scaled correction, inverse-mass sum and status.
// ----------------------------------------------------------------------------
module cpc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpc_pkg::POS_W-1:0]    pos_a_x,
  input  logic signed [cpc_pkg::POS_W-1:0]    pos_a_y,
  input  logic signed [cpc_pkg::POS_W-1:0]    pos_a_z,
  input  logic signed [cpc_pkg::POS_W-1:0]    pos_b_x,
  input  logic signed [cpc_pkg::POS_W-1:0]    pos_b_y,
  input  logic signed [cpc_pkg::POS_W-1:0]    pos_b_z,
  input  logic [3*cpc_pkg::NORM_W-1:0]        normal_packed,
  input  logic signed [cpc_pkg::POS_W-1:0]    depth,
  input  logic [cpc_pkg::MASS_W-1:0]          inv_mass_a,
  input  logic [cpc_pkg::MASS_W-1:0]          inv_mass_b,
  input  logic                                static_a,
  input  logic                                static_b,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cpc_pkg::REG_W-1:0]           cfg_data,
  input  logic                                q_full,
  output cpc_pkg::cpc_link_t                  push
);

  localparam int PW = cpc_pkg::POS_W;
  localparam int RW = cpc_pkg::REG_W;
  localparam int MW = cpc_pkg::MASS_W;
  localparam int PEN_W = PW + 1;
  localparam int PROD_W = (PW - 1) + RW;

  logic [RW-1:0]          slop;
  logic [RW-1:0]          share;

  logic                   f1_valid;
  logic [2:0][PW-1:0]     f1_pos_a;
  logic [2:0][PW-1:0]     f1_pos_b;
  logic [3*cpc_pkg::NORM_W-1:0] f1_normal;
  logic [MW-1:0]          f1_ima;
  logic [MW-1:0]          f1_imb;
  logic                   f1_sa;
  logic                   f1_sb;
  logic [PEN_W-1:0]       f1_pen;

  logic [PEN_W-1:0]       pen_in;
  logic [PROD_W-1:0]      scale_prod;
  logic [MW:0]            mass_sum;
  logic                   pen_pos;
  cpc_pkg::cpc_status_t   status_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slop  <= cpc_pkg::SLOP_RESET;
      share <= cpc_pkg::SHARE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == cpc_pkg::CFG_SLOP) begin
        slop <= cfg_data;
      end else if (cfg_index == cpc_pkg::CFG_SHARE) begin
        share <= cfg_data;
      end
    end
  end

  assign in_ready = !f1_valid || !q_full;
  assign pen_in   = {depth[PW-1], depth} - {{(PEN_W-RW){1'b0}}, slop};

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (in_ready) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f1_pos_a  <= {pos_a_z, pos_a_y, pos_a_x};
      f1_pos_b  <= {pos_b_z, pos_b_y, pos_b_x};
      f1_normal <= normal_packed;
      f1_ima    <= inv_mass_a;
      f1_imb    <= inv_mass_b;
      f1_sa     <= static_a;
      f1_sb     <= static_b;
      f1_pen    <= pen_in;
    end
  end

  // A positive penetration never exceeds 2^31 - 1, so its low bits carry it.
  assign pen_pos    = !f1_pen[PEN_W-1] && (f1_pen != '0);
  assign scale_prod = PROD_W'(f1_pen[PW-2:0]) * PROD_W'(share);
  assign mass_sum   = {1'b0, f1_ima} + {1'b0, f1_imb};

  always_comb begin
    if (f1_sa && f1_sb) begin
      status_c = cpc_pkg::ST_BOTH_STATIC;
    end else if (!pen_pos) begin
      status_c = cpc_pkg::ST_IN_SLOP;
    end else if (!f1_sa && !f1_sb && (mass_sum == '0)) begin
      status_c = cpc_pkg::ST_ZERO_SUM;
    end else begin
      status_c = cpc_pkg::ST_CORRECTED;
    end
  end

  always_comb begin
    push.valid           = f1_valid && !q_full;
    push.item.pos_a      = f1_pos_a;
    push.item.pos_b      = f1_pos_b;
    push.item.normal     = f1_normal;
    push.item.inv_mass_a = f1_ima;
    push.item.mass_sum   = mass_sum;
    push.item.scaled     = scale_prod[cpc_pkg::SHARE_FRAC +: PW];
    push.item.status     = status_c;
    push.item.static_a   = f1_sa;
    push.item.static_b   = f1_sb;
  end

endmodule

// ----- design/cpc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module cpc_queue #(
  parameter int DEPTH = cpc_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic               clk,
  input  logic               rst,
  input  cpc_pkg::cpc_link_t push,
  output logic               full,
  output cpc_pkg::cpc_link_t head,
  input  logic               pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpc_pkg::cpc_item_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/cpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_back
// Carries out the correction: share split through a pipelined divider,
// normal projection, rounding and saturated position update.
// ----------------------------------------------------------------------------
module cpc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  cpc_pkg::cpc_link_t                head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cpc_pkg::POS_W-1:0]  new_a_x,
  output logic signed [cpc_pkg::POS_W-1:0]  new_a_y,
  output logic signed [cpc_pkg::POS_W-1:0]  new_a_z,
  output logic signed [cpc_pkg::POS_W-1:0]  new_b_x,
  output logic signed [cpc_pkg::POS_W-1:0]  new_b_y,
  output logic signed [cpc_pkg::POS_W-1:0]  new_b_z,
  output logic [1:0]                        status
);

  localparam int PW     = cpc_pkg::POS_W;
  localparam int NW     = cpc_pkg::NORM_W;
  localparam int MW     = cpc_pkg::MASS_W;
  localparam int NSTEPS = PW;                 // one quotient bit per stage
  localparam int PRD_W  = NW + PW + 1;
  localparam int DLT_W  = PRD_W - cpc_pkg::NORM_FRAC;
  localparam int SUM_W  = DLT_W + 1;
  localparam logic signed [PRD_W-1:0] HALF_LSB = PRD_W'(1) <<< (cpc_pkg::NORM_FRAC - 1);

  typedef struct packed {
    logic [2:0][PW-1:0]     pos_a;
    logic [2:0][PW-1:0]     pos_b;
    logic [3*NW-1:0]        normal;
    logic [PW-1:0]          scaled;
    logic [MW:0]            mass_sum;
    cpc_pkg::cpc_status_t   status;
    logic                   static_a;
    logic                   static_b;
    logic [MW:0]            rem;
    logic [PW-1:0]          qlo;      // dividend bits shifting out, quotient in
  } cpc_div_t;

  function automatic logic [PW-1:0] sat_pos(input logic [SUM_W-1:0] v);
    logic [SUM_W-PW:0] top;
    top = v[SUM_W-1:PW-1];
    if ((top == '0) || (top == '1)) begin
      sat_pos = v[PW-1:0];
    end else if (v[SUM_W-1]) begin
      sat_pos = {1'b1, {(PW-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(PW-1){1'b1}}};
    end
  endfunction

  logic                   adv;
  logic [2*PW-1:0]        dvd;
  cpc_div_t               st [NSTEPS+1];
  logic [NSTEPS:0]        st_valid;

  logic                   mv_valid;
  logic [2:0][PW-1:0]     mv_pos_a;
  logic [2:0][PW-1:0]     mv_pos_b;
  logic [3*NW-1:0]        mv_normal;
  logic [PW-1:0]          mv_move_a;
  logic [PW-1:0]          mv_move_b;
  cpc_pkg::cpc_status_t   mv_status;
  logic [PW-1:0]          move_a_c;
  logic [PW-1:0]          move_b_c;

  logic                        prd_valid;
  logic [2:0][PW-1:0]          prd_pos_a;
  logic [2:0][PW-1:0]          prd_pos_b;
  logic signed [PRD_W-1:0]     prd_a [3];
  logic signed [PRD_W-1:0]     prd_b [3];
  cpc_pkg::cpc_status_t        prd_status;

  logic                        dlt_valid;
  logic [2:0][PW-1:0]          dlt_pos_a;
  logic [2:0][PW-1:0]          dlt_pos_b;
  logic [DLT_W-1:0]            dlt_a [3];
  logic [DLT_W-1:0]            dlt_b [3];
  cpc_pkg::cpc_status_t        dlt_status;

  logic [2:0][PW-1:0]          out_a;
  logic [2:0][PW-1:0]          out_b;
  cpc_pkg::cpc_status_t        out_status;

  // The whole back pipeline moves together; it stops only on a held result.
  assign adv = !out_valid || out_ready;
  assign pop = adv;
  assign dvd = (2*PW)'(head.item.scaled) * (2*PW)'(head.item.inv_mass_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= '0;
      mv_valid  <= 1'b0;
      prd_valid <= 1'b0;
      dlt_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      st_valid  <= {st_valid[NSTEPS-1:0], head.valid};
      mv_valid  <= st_valid[NSTEPS];
      prd_valid <= mv_valid;
      dlt_valid <= prd_valid;
      out_valid <= dlt_valid;
    end
  end

  // scaled * inv_mass_a < 2^32 * mass_sum, so the upper half is already
  // below the divisor and 32 restoring steps give the whole quotient.
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].pos_a    <= head.item.pos_a;
      st[0].pos_b    <= head.item.pos_b;
      st[0].normal   <= head.item.normal;
      st[0].scaled   <= head.item.scaled;
      st[0].mass_sum <= head.item.mass_sum;
      st[0].status   <= head.item.status;
      st[0].static_a <= head.item.static_a;
      st[0].static_b <= head.item.static_b;
      st[0].rem      <= {1'b0, dvd[2*PW-1:PW]};
      st[0].qlo      <= dvd[PW-1:0];
    end
  end

  for (genvar k = 0; k < NSTEPS; k++) begin : g_div
    logic [MW+1:0] r2;
    logic [MW+2:0] diff;
    logic          ge;
    cpc_div_t      nx;

    always_comb begin
      nx     = st[k];
      r2     = {st[k].rem, st[k].qlo[PW-1]};
      diff   = {1'b0, r2} - {2'b00, st[k].mass_sum};
      ge     = !diff[MW+2];
      nx.rem = ge ? diff[MW:0] : r2[MW:0];
      nx.qlo = {st[k].qlo[PW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k+1] <= nx;
      end
    end
  end

  // B's share follows from A's: floor(s*mb/t) = s - q - (remainder != 0).
  always_comb begin
    move_a_c = '0;
    move_b_c = '0;
    if (st[NSTEPS].status == cpc_pkg::ST_CORRECTED) begin
      if (st[NSTEPS].static_a) begin
        move_b_c = st[NSTEPS].scaled;
      end else if (st[NSTEPS].static_b) begin
        move_a_c = st[NSTEPS].scaled;
      end else begin
        move_a_c = st[NSTEPS].qlo;
        move_b_c = st[NSTEPS].scaled - st[NSTEPS].qlo
                   - PW'(st[NSTEPS].rem != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mv_pos_a  <= st[NSTEPS].pos_a;
      mv_pos_b  <= st[NSTEPS].pos_b;
      mv_normal <= st[NSTEPS].normal;
      mv_move_a <= move_a_c;
      mv_move_b <= move_b_c;
      mv_status <= st[NSTEPS].status;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prd_pos_a  <= mv_pos_a;
      prd_pos_b  <= mv_pos_b;
      prd_status <= mv_status;
      for (int i = 0; i < 3; i++) begin
        prd_a[i] <= $signed(mv_normal[NW*i +: NW]) * $signed({1'b0, mv_move_a});
        prd_b[i] <= $signed(mv_normal[NW*i +: NW]) * $signed({1'b0, mv_move_b});
      end
    end
  end

  // Round to nearest, ties up: add half an LSB, keep the upper bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      dlt_pos_a  <= prd_pos_a;
      dlt_pos_b  <= prd_pos_b;
      dlt_status <= prd_status;
      for (int i = 0; i < 3; i++) begin
        dlt_a[i] <= DLT_W'((prd_a[i] + HALF_LSB) >>> cpc_pkg::NORM_FRAC);
        dlt_b[i] <= DLT_W'((prd_b[i] + HALF_LSB) >>> cpc_pkg::NORM_FRAC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= dlt_status;
      for (int i = 0; i < 3; i++) begin
        out_a[i] <= sat_pos({{(SUM_W-PW){dlt_pos_a[i][PW-1]}}, dlt_pos_a[i]}
                            - {dlt_a[i][DLT_W-1], dlt_a[i]});
        out_b[i] <= sat_pos({{(SUM_W-PW){dlt_pos_b[i][PW-1]}}, dlt_pos_b[i]}
                            + {dlt_b[i][DLT_W-1], dlt_b[i]});
      end
    end
  end

  assign new_a_x = out_a[0];
  assign new_a_y = out_a[1];
  assign new_a_z = out_a[2];
  assign new_b_x = out_b[0];
  assign new_b_y = out_b[1];
  assign new_b_z = out_b[2];
  assign status  = out_status;

endmodule

// ----- design/contact_penetration_correction.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_penetration_correction
// Linear projection position correction for one contact per item.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_ready     pos_a_*, pos_b_*, normal_packed, depth,
//                                   inv_mass_a/b, static_a/b
//  out      out_valid / out_ready   new_a_*, new_b_*, status
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (0 slop, 1 share)
//
//  One item per cycle sustained while out_ready is high. The 32-stage
//  restoring divider that splits the correction holds most of the pipeline.
//  Synchronous reset clears all valid bits and restores the two registers.
//  A held result freezes the back pipeline; the front keeps taking items
//  until the queue between them (QUEUE_DEPTH entries) fills.
// ----------------------------------------------------------------------------
module contact_penetration_correction #(
  parameter int QUEUE_DEPTH = cpc_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cpc_pkg::POS_W-1:0]  pos_a_x,
  input  logic signed [cpc_pkg::POS_W-1:0]  pos_a_y,
  input  logic signed [cpc_pkg::POS_W-1:0]  pos_a_z,
  input  logic signed [cpc_pkg::POS_W-1:0]  pos_b_x,
  input  logic signed [cpc_pkg::POS_W-1:0]  pos_b_y,
  input  logic signed [cpc_pkg::POS_W-1:0]  pos_b_z,
  input  logic [3*cpc_pkg::NORM_W-1:0]      normal_packed,
  input  logic signed [cpc_pkg::POS_W-1:0]  depth,
  input  logic [cpc_pkg::MASS_W-1:0]        inv_mass_a,
  input  logic [cpc_pkg::MASS_W-1:0]        inv_mass_b,
  input  logic                              static_a,
  input  logic                              static_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cpc_pkg::POS_W-1:0]  new_a_x,
  output logic signed [cpc_pkg::POS_W-1:0]  new_a_y,
  output logic signed [cpc_pkg::POS_W-1:0]  new_a_z,
  output logic signed [cpc_pkg::POS_W-1:0]  new_b_x,
  output logic signed [cpc_pkg::POS_W-1:0]  new_b_y,
  output logic signed [cpc_pkg::POS_W-1:0]  new_b_z,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpc_pkg::REG_W-1:0]         cfg_data
);

  cpc_pkg::cpc_link_t push;
  cpc_pkg::cpc_link_t head;
  logic               q_full;
  logic               pop;

  cpc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pos_a_x       (pos_a_x),
    .pos_a_y       (pos_a_y),
    .pos_a_z       (pos_a_z),
    .pos_b_x       (pos_b_x),
    .pos_b_y       (pos_b_y),
    .pos_b_z       (pos_b_z),
    .normal_packed (normal_packed),
    .depth         (depth),
    .inv_mass_a    (inv_mass_a),
    .inv_mass_b    (inv_mass_b),
    .static_a      (static_a),
    .static_b      (static_b),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .push          (push)
  );

  cpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  cpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_a_x   (new_a_x),
    .new_a_y   (new_a_y),
    .new_a_z   (new_a_z),
    .new_b_x   (new_b_x),
    .new_b_y   (new_b_y),
    .new_b_z   (new_b_z),
    .status    (status)
  );

endmodule

// ----- design/cpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_checker
// Port-level checks on the correction block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              cfg_ready,
  input logic signed [cpc_pkg::POS_W-1:0]  new_a_x,
  input logic signed [cpc_pkg::POS_W-1:0]  new_b_z,
  input logic [1:0]                        status
);

  `CPC_ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")
  `CPC_ASSERT_RST(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(new_a_x) && $stable(new_b_z) && $stable(status), "result payload changed while stalled")
  `CPC_ASSERT(a_rst_out, clk, rst |=> !out_valid, "result valid right after reset")
  `CPC_ASSERT(a_rst_in, clk, rst |=> in_ready && cfg_ready, "block not ready right after reset")

endmodule

bind contact_penetration_correction cpc_checker u_cpc_checker (.*);

// ----- tb/correction_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// correction_checker
// Watches the contact, result and register channels of the penetration
// correction block, predicts each corrected contact from its own copy of
// slop and correction share, and compares results field by field in order.
// ----------------------------------------------------------------------------
module correction_checker import cpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [POS_W-1:0]         pos_a_x,
  input  logic [POS_W-1:0]         pos_a_y,
  input  logic [POS_W-1:0]         pos_a_z,
  input  logic [POS_W-1:0]         pos_b_x,
  input  logic [POS_W-1:0]         pos_b_y,
  input  logic [POS_W-1:0]         pos_b_z,
  input  logic [3*NORM_W-1:0]      normal_packed,
  input  logic [POS_W-1:0]         depth,
  input  logic [MASS_W-1:0]        inv_mass_a,
  input  logic [MASS_W-1:0]        inv_mass_b,
  input  logic                     static_a,
  input  logic                     static_b,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [POS_W-1:0]         new_a_x,
  input  logic [POS_W-1:0]         new_a_y,
  input  logic [POS_W-1:0]         new_a_z,
  input  logic [POS_W-1:0]         new_b_x,
  input  logic [POS_W-1:0]         new_b_y,
  input  logic [POS_W-1:0]         new_b_z,
  input  logic [1:0]               status,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  output int                       pending,
  output int                       fail_count
);

  typedef struct packed {
    logic [2:0][POS_W-1:0]   pos_a;
    logic [2:0][POS_W-1:0]   pos_b;
    logic [3*NORM_W-1:0]     normal;
    logic signed [POS_W-1:0] depth;
    logic [MASS_W-1:0]       inv_mass_a;
    logic [MASS_W-1:0]       inv_mass_b;
    logic                    static_a;
    logic                    static_b;
  } contact_t;

  typedef struct packed {
    logic [2:0][POS_W-1:0] new_a;
    logic [2:0][POS_W-1:0] new_b;
    cpc_status_t           status;
  } correction_t;

  localparam longint ROUND_HALF = longint'(1) <<< (NORM_FRAC - 1);
  localparam longint POS_MAX    = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN    = -(longint'(1) <<< (POS_W - 1));

  logic [REG_W-1:0] slop_q;
  logic [REG_W-1:0] share_q;
  correction_t      corrections_due[$];

  initial fail_count = 0;

  function automatic logic [POS_W-1:0] clamp_q16(longint v);
    if (v > POS_MAX) return POS_W'(POS_MAX);
    if (v < POS_MIN) return POS_W'(POS_MIN);
    return POS_W'(v);
  endfunction

  function automatic correction_t predict_correction(contact_t c);
    correction_t r;
    longint      pen, move_a, move_b, nrm, delta_a, delta_b;
    logic [63:0] scaled, total;
    move_a   = 0;
    move_b   = 0;
    r.status = ST_CORRECTED;
    pen      = longint'(c.depth) - longint'(slop_q);
    total    = 64'(c.inv_mass_a) + 64'(c.inv_mass_b);
    if (c.static_a && c.static_b) begin
      r.status = ST_BOTH_STATIC;
    end else if (pen <= 0) begin
      r.status = ST_IN_SLOP;
    end else begin
      scaled = (64'(pen) * 64'(share_q)) >> SHARE_FRAC;
      if (c.static_a) begin
        move_b = longint'(scaled);
      end else if (c.static_b) begin
        move_a = longint'(scaled);
      end else if (total == 0) begin
        r.status = ST_ZERO_SUM;
      end else begin
        // split by inverse-mass share; product fits 64 bits unsigned
        move_a = longint'((scaled * 64'(c.inv_mass_a)) / total);
        move_b = longint'((scaled * 64'(c.inv_mass_b)) / total);
      end
    end
    for (int i = 0; i < 3; i++) begin
      nrm        = longint'($signed(c.normal[NORM_W*i +: NORM_W]));
      // round to nearest, ties toward +inf (arithmetic shift floors)
      delta_a    = (nrm * move_a + ROUND_HALF) >>> NORM_FRAC;
      delta_b    = (nrm * move_b + ROUND_HALF) >>> NORM_FRAC;
      r.new_a[i] = clamp_q16(longint'($signed(c.pos_a[i])) - delta_a);
      r.new_b[i] = clamp_q16(longint'($signed(c.pos_b[i])) + delta_b);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] exp_v, logic [POS_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    contact_t    c;
    correction_t exp_r;
    if (rst) begin
      slop_q  = SLOP_RESET;
      share_q = SHARE_RESET;
      corrections_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (corrections_due.size() == 0) begin
          $error("result item with no contact outstanding");
          fail_count++;
        end else begin
          exp_r = corrections_due.pop_front();
          check_field("new_a_x", exp_r.new_a[0], new_a_x);
          check_field("new_a_y", exp_r.new_a[1], new_a_y);
          check_field("new_a_z", exp_r.new_a[2], new_a_z);
          check_field("new_b_x", exp_r.new_b[0], new_b_x);
          check_field("new_b_y", exp_r.new_b[1], new_b_y);
          check_field("new_b_z", exp_r.new_b[2], new_b_z);
          check_field("status", POS_W'(exp_r.status), POS_W'(status));
        end
      end
      if (in_valid && in_ready) begin
        c.pos_a      = {pos_a_z, pos_a_y, pos_a_x};
        c.pos_b      = {pos_b_z, pos_b_y, pos_b_x};
        c.normal     = normal_packed;
        c.depth      = depth;
        c.inv_mass_a = inv_mass_a;
        c.inv_mass_b = inv_mass_b;
        c.static_a   = static_a;
        c.static_b   = static_b;
        corrections_due.push_back(predict_correction(c));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLOP:  slop_q  = cfg_data;
          CFG_SHARE: share_q = cfg_data;
          default: ;  // unmapped index, write dropped
        endcase
      end
    end
    pending = corrections_due.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives contacts into the penetration correction block under bursty input
// and a stalling receiver, steps slop and correction share through their
// extremes between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int PHASE_ITEMS = 280;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [2:0][POS_W-1:0]   pos_a;
    logic [2:0][POS_W-1:0]   pos_b;
    logic [3*NORM_W-1:0]     normal;
    logic [POS_W-1:0]        depth;
    logic [MASS_W-1:0]       inv_mass_a;
    logic [MASS_W-1:0]       inv_mass_b;
    logic                    static_a;
    logic                    static_b;
  } contact_t;

  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [POS_W-1:0]     pos_a_x, pos_a_y, pos_a_z;
  logic [POS_W-1:0]     pos_b_x, pos_b_y, pos_b_z;
  logic [3*NORM_W-1:0]  normal_packed;
  logic [POS_W-1:0]     depth;
  logic [MASS_W-1:0]    inv_mass_a, inv_mass_b;
  logic                 static_a, static_b;
  logic                 out_valid;
  logic                 out_ready;
  logic [POS_W-1:0]     new_a_x, new_a_y, new_a_z;
  logic [POS_W-1:0]     new_b_x, new_b_y, new_b_z;
  logic [1:0]           status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  int                   pending;
  int                   fail_count;

  int                   items_sent;
  int                   burst_left;
  logic [REG_W-1:0]     slop_now;

  contact_penetration_correction u_top (
    .clk, .rst, .in_valid, .in_ready,
    .pos_a_x, .pos_a_y, .pos_a_z, .pos_b_x, .pos_b_y, .pos_b_z,
    .normal_packed, .depth, .inv_mass_a, .inv_mass_b, .static_a, .static_b,
    .out_valid, .out_ready,
    .new_a_x, .new_a_y, .new_a_z, .new_b_x, .new_b_y, .new_b_z, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  correction_checker u_checker (
    .clk, .rst, .in_valid, .in_ready,
    .pos_a_x, .pos_a_y, .pos_a_z, .pos_b_x, .pos_b_y, .pos_b_z,
    .normal_packed, .depth, .inv_mass_a, .inv_mass_b, .static_a, .static_b,
    .out_valid, .out_ready,
    .new_a_x, .new_a_y, .new_a_z, .new_b_x, .new_b_y, .new_b_z, .status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic contact_t base_contact();
    contact_t c;
    c.pos_a      = {32'h0000_8000, 32'hFFFE_0000, 32'h0003_0000};
    c.pos_b      = {32'hFFFF_C000, 32'h0001_0000, 32'h0004_0000};
    c.normal     = {16'h0000, 16'h0000, 16'h4000};
    c.depth      = 32'h0002_0000;
    c.inv_mass_a = 32'h0001_0000;
    c.inv_mass_b = 32'h0000_8000;
    c.static_a   = 1'b0;
    c.static_b   = 1'b0;
    return c;
  endfunction

  function automatic logic [POS_W-1:0] random_coord();
    if ($urandom_range(0, 9) != 0) return $urandom;
    // near the rails so corrections saturate
    if ($urandom_range(0, 1) == 1) return 32'h7FFF_FFFF - $urandom_range(0, 65535);
    return 32'h8000_0000 + $urandom_range(0, 65535);
  endfunction

  function automatic logic [MASS_W-1:0] random_mass();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return '0;
    if (pick < 45) return $urandom;
    return $urandom_range(0, 1 << $urandom_range(0, 24));
  endfunction

  function automatic contact_t random_contact();
    contact_t    c;
    int unsigned pick;
    for (int i = 0; i < 3; i++) begin
      c.pos_a[i] = random_coord();
      c.pos_b[i] = random_coord();
      if ($urandom_range(0, 1) == 1)
        c.normal[NORM_W*i +: NORM_W] = 16'($urandom);
      else
        c.normal[NORM_W*i +: NORM_W] = 16'($urandom_range(0, 32768) - 16384);
    end
    pick = $urandom_range(0, 99);
    if (pick < 65)
      c.depth = 32'(slop_now) + $urandom_range(1, 1 << $urandom_range(0, 30));
    else if (pick < 80)
      c.depth = 32'(slop_now) + $urandom_range(0, 4) - 2;  // around the slop edge
    else
      c.depth = $urandom;
    pick = $urandom_range(0, 99);
    c.static_a = (pick >= 70 && pick < 82) || pick >= 94;
    c.static_b = pick >= 82;
    c.inv_mass_a = random_mass();
    c.inv_mass_b = random_mass();
    if ($urandom_range(0, 19) == 0) begin
      c.inv_mass_a = '0;
      c.inv_mass_b = '0;
    end
    return c;
  endfunction

  task automatic offer_contact(contact_t c);
    @(negedge clk);
    pos_a_x       <= c.pos_a[0];
    pos_a_y       <= c.pos_a[1];
    pos_a_z       <= c.pos_a[2];
    pos_b_x       <= c.pos_b[0];
    pos_b_y       <= c.pos_b[1];
    pos_b_z       <= c.pos_b[2];
    normal_packed <= c.normal;
    depth         <= c.depth;
    inv_mass_a    <= c.inv_mass_a;
    inv_mass_b    <= c.inv_mass_b;
    static_a      <= c.static_a;
    static_b      <= c.static_b;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLOP) slop_now = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(logic [REG_W-1:0] slop_val, logic [REG_W-1:0] share_val);
    wait_drained();
    write_reg(CFG_SLOP, slop_val);
    write_reg(CFG_SHARE, share_val);
  endtask

  task automatic run_random(int count);
    int gap;
    for (int n = 0; n < count; n++) begin
      offer_contact(random_contact());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  // receiver: random stall patterns, plus two long hold-offs while the
  // sender keeps pushing so the block backs up into its input
  initial begin
    rx_mode_t mode;
    int       seg;
    int       holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ((holds_done == 0 && items_sent >= 400) || (holds_done == 1 && items_sent >= 1300)) begin
        repeat (400) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        holds_done++;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(10, 80);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_COIN:   out_ready <= $urandom_range(0, 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    contact_t c;
    rst           = 1'b1;
    in_valid      = 1'b0;
    pos_a_x       = '0;
    pos_a_y       = '0;
    pos_a_z       = '0;
    pos_b_x       = '0;
    pos_b_y       = '0;
    pos_b_z       = '0;
    normal_packed = '0;
    depth         = '0;
    inv_mass_a    = '0;
    inv_mass_b    = '0;
    static_a      = 1'b0;
    static_b      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SLOP;
    cfg_data      = '0;
    items_sent    = 0;
    burst_left    = 1;
    slop_now      = SLOP_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed contacts, reset register values
    c = base_contact();
    offer_contact(c);
    c.static_a = 1'b1;
    c.static_b = 1'b1;
    offer_contact(c);
    c = base_contact();
    c.depth = 32'(SLOP_RESET);          // exactly at slop
    offer_contact(c);
    c.depth = 32'(SLOP_RESET) + 1;
    offer_contact(c);
    c.depth = 32'h8000_0000;
    offer_contact(c);
    c = base_contact();
    c.inv_mass_a = '0;
    c.inv_mass_b = '0;
    offer_contact(c);                   // zero inverse-mass sum
    c.static_a = 1'b1;
    offer_contact(c);                   // one static body ignores the masses
    c.static_a = 1'b0;
    c.static_b = 1'b1;
    offer_contact(c);
    c = base_contact();
    c.depth      = 32'h7FFF_FFFF;
    c.inv_mass_a = 32'hFFFF_FFFF;
    c.inv_mass_b = 32'hFFFF_FFFF;
    offer_contact(c);
    c.inv_mass_b = '0;
    offer_contact(c);
    c.inv_mass_a = '0;
    c.inv_mass_b = 32'h0000_0001;
    offer_contact(c);
    c = base_contact();
    c.depth    = 32'h7FFF_FFFF;
    c.static_a = 1'b1;
    c.normal   = {16'h7FFF, 16'h8000, 16'h7FFF};
    c.pos_b    = {32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    offer_contact(c);                   // B saturates both ways
    c.static_a = 1'b0;
    c.static_b = 1'b1;
    c.pos_a    = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    offer_contact(c);                   // A saturates both ways
    c = base_contact();
    c.normal = '0;
    offer_contact(c);
    // scaled lands on 8192, so +/-1 normals hit rounding ties
    c = base_contact();
    c.static_b = 1'b1;
    c.depth    = 32'(SLOP_RESET) + 10240;
    c.normal   = {16'd3, 16'hFFFF, 16'd1};
    offer_contact(c);
    c.static_b = 1'b0;
    offer_contact(c);
    run_random(PHASE_ITEMS);

    reconfigure(17'd0, 17'd65536);
    run_random(PHASE_ITEMS);
    reconfigure(17'd65536, 17'd0);
    write_reg(CFG_SPARE_LO, 17'h1FFFF);
    write_reg(CFG_SPARE_HI, REG_W'($urandom));
    run_random(PHASE_ITEMS / 2);
    wait_drained();                     // sender waits out every result
    run_random(PHASE_ITEMS / 2);
    reconfigure(17'h1FFFF, 17'h1FFFF);
    run_random(PHASE_ITEMS);
    reconfigure(17'd1, 17'd1);
    run_random(PHASE_ITEMS);
    reconfigure(REG_W'($urandom_range(0, 65536)), REG_W'($urandom_range(0, 65536)));
    run_random(PHASE_ITEMS);
    reconfigure(SLOP_RESET, 17'd65536);
    run_random(PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cpc_pkg.sv
design/cpc_front.sv
design/cpc_queue.sv
design/cpc_back.sv
design/contact_penetration_correction.sv
design/cpc_checker.sv
tb/correction_checker.sv
tb/testbench.sv
